// ===== design/wbps_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// wbps_pkg
// Shared constants and types of the wildcard byte pattern scanner.
// ============================================================================
package wbps_pkg;

    // Defaults of the top level parameters.
    localparam int PATTERN_MAX_DEF  = 16;
    localparam int OFFSET_WIDTH_DEF = 32;

    // Pattern positions that the configuration registers can hold.
    localparam int PATTERN_STORE = 16;
    localparam int HALF_STORE    = 8;

    // Field widths fixed by the register map and the result format.
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 32;
    localparam int PLEN_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WILDCARD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE         = 3'd4;

    typedef logic [BYTE_W-1:0] t_byte;

endpackage

// ===== design/wildcard_byte_pattern_scan_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// wildcard_byte_pattern_scan_core
// Streaming scanner that finds the first match of a wildcard byte pattern
// in a region of memory and reports its address, or reports not found.
// ============================================================================
//
//  Channel  | Direction | Signals                         | Content
//  ---------+-----------+---------------------------------+---------------------------
//  s        | in        | i_s_tvalid o_s_tready i_s_tdata | data_byte [7:0]
//           |           | i_s_tlast                       | last_byte
//  m        | out       | o_m_tvalid i_m_tready o_m_tdata | found [0], match_address [32:1]
//  cfg      | in        | i_cfg_valid o_cfg_ready         | i_cfg_index, i_cfg_data
//
//  One byte is taken per cycle while no result waits on a stalled master
//  side; a byte's result appears on the master side in the next cycle,
//  from the output register. The rate is set by the combinational window compare.
//  Reset is synchronous and active low; it clears the registers, the byte
//  count and the output valid flag. A stalled master side holds the pending
//  result; the slave side keeps taking bytes while the master takes it.
//
// The window is a row of cells. Cell k sees the byte k steps back from the
// current one (cell 0 sees the incoming byte) and compares it with the
// pattern position that lines up with it for the configured length. A match
// needs every cell to agree and enough bytes seen in this scan, so stale
// window bytes from earlier scans never take part and the window needs no
// clearing at the end of a scan.
// ============================================================================
module wildcard_byte_pattern_scan_core
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX  = PATTERN_MAX_DEF,
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input byte stream. tdata: data_byte [7:0].
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,
    input  logic                  i_s_tlast,
    // Result stream. tdata: found [0], match_address [32:1], zeros [39:33].
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [39:0]           o_m_tdata,
    // Configuration writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int SUM_W = (OFFSET_WIDTH > ADDR_W) ? OFFSET_WIDTH : ADDR_W;

    // Configuration registers.
    logic [CFG_DATA_W-1:0]    r_pat_lo;
    logic [CFG_DATA_W-1:0]    r_pat_hi;
    logic [PATTERN_STORE-1:0] r_wild;
    logic [PLEN_W-1:0]        r_len;
    logic [ADDR_W-1:0]        r_base;

    // Scan state.
    logic [OFFSET_WIDTH-1:0]  r_count;
    logic                     r_reported;

    // Output register.
    logic                     r_out_valid;
    logic                     r_out_found;
    logic [ADDR_W-1:0]        r_out_addr;

    logic                          accept;
    logic [LEN_W-1:0]              len_c;
    logic [PATTERN_MAX*BYTE_W-1:0] pattern;
    logic [PATTERN_MAX-1:0]        wild;
    t_byte                         chain [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]        cell_ok;
    logic                          count_ok;
    logic                          match;
    logic                          result;
    logic [OFFSET_WIDTH-1:0]       start;
    logic [ADDR_W-1:0]             address;

    // ------------------------------------------------------------------
    // Configuration port: always ready, one register per transfer.
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_wild   <= '0;
            r_len    <= '0;
            r_base   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PATTERN_LOW:  r_pat_lo <= i_cfg_data;
                REG_PATTERN_HIGH: r_pat_hi <= i_cfg_data;
                REG_WILDCARD:     r_wild   <= i_cfg_data[PATTERN_STORE-1:0];
                REG_LENGTH:       r_len    <= i_cfg_data[PLEN_W-1:0];
                REG_BASE:         r_base   <= i_cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pattern as seen by the cells. Positions past the stored sixteen read
    // as zero bytes and are never wildcards. The length is clamped to the
    // number of cells.
    // ------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (i < HALF_STORE) begin
                pattern[i*BYTE_W +: BYTE_W] = r_pat_lo[i*BYTE_W +: BYTE_W];
                wild[i] = r_wild[i];
            end else if (i < PATTERN_STORE) begin
                pattern[i*BYTE_W +: BYTE_W] = r_pat_hi[(i-HALF_STORE)*BYTE_W +: BYTE_W];
                wild[i] = r_wild[i];
            end else begin
                pattern[i*BYTE_W +: BYTE_W] = '0;
                wild[i] = 1'b0;
            end
        end
        if (32'(r_len) > 32'(PATTERN_MAX)) begin
            len_c = LEN_W'(PATTERN_MAX);
        end else begin
            len_c = LEN_W'(r_len);
        end
    end

    // ------------------------------------------------------------------
    // Row of window cells. The incoming byte enters cell 0 and moves one
    // cell further on every accepted byte.
    // ------------------------------------------------------------------
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign chain[0]   = i_s_tdata;

    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        if (k < PATTERN_MAX - 1) begin : g_link
            wbps_cell #(
                .PATTERN_MAX (PATTERN_MAX),
                .INDEX       (k)
            ) u_cell (
                .i_clk     (i_clk),
                .i_shift   (accept),
                .i_byte    (chain[k]),
                .o_byte    (chain[k+1]),
                .i_pattern (pattern),
                .i_wild    (wild),
                .i_len     (len_c),
                .o_ok      (cell_ok[k])
            );
        end else begin : g_end
            // The oldest cell's held byte would be older than any pattern
            // can reach, so nothing reads it.
            wbps_cell #(
                .PATTERN_MAX (PATTERN_MAX),
                .INDEX       (k)
            ) u_cell (
                .i_clk     (i_clk),
                .i_shift   (accept),
                .i_byte    (chain[k]),
                .o_byte    (),
                .i_pattern (pattern),
                .i_wild    (wild),
                .i_len     (len_c),
                .o_ok      (cell_ok[k])
            );
        end
    end

    // ------------------------------------------------------------------
    // Match decision and match address. The match starts count+1-length
    // bytes into the region.
    // ------------------------------------------------------------------
    always_comb begin
        count_ok = ((OFFSET_WIDTH+1)'(r_count) + (OFFSET_WIDTH+1)'(1))
                   >= (OFFSET_WIDTH+1)'(len_c);
        match    = (len_c != '0) && !r_reported && count_ok && (&cell_ok);
        result   = match || (i_s_tlast && !r_reported);
        start    = r_count + OFFSET_WIDTH'(1) - OFFSET_WIDTH'(len_c);
        address  = ADDR_W'(SUM_W'(r_base) + SUM_W'(start));
    end

    // Byte count (saturating) and the reported flag; both clear when the
    // last byte of a region has been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_reported <= 1'b0;
        end else if (accept) begin
            if (i_s_tlast) begin
                r_count    <= '0;
                r_reported <= 1'b0;
            end else begin
                if (r_count != '1) begin
                    r_count <= r_count + OFFSET_WIDTH'(1);
                end
                if (match) begin
                    r_reported <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register. It is loaded only when empty or being emptied in
    // the same cycle, which is exactly when a byte can be taken.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && result) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && result) begin
            r_out_found <= match;
            r_out_addr  <= match ? address : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_addr, r_out_found};

endmodule

// ===== design/wbps_cell.sv =====
`timescale 1ns / 1ps
// ============================================================================
// wbps_cell
// One window cell: holds one byte of the sliding window, hands it to the
// next cell on every shift and checks the byte it sees against the pattern
// position that lines up with it for the current pattern length.
// ============================================================================
module wbps_cell
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int INDEX       = 0,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1),
    parameter int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_shift,
    input  t_byte                         i_byte,
    output t_byte                         o_byte,
    input  logic [PATTERN_MAX*BYTE_W-1:0] i_pattern,
    input  logic [PATTERN_MAX-1:0]        i_wild,
    input  logic [LEN_W-1:0]              i_len,
    output logic                          o_ok
);

    localparam logic [LEN_W-1:0] CELL_POS = LEN_W'(INDEX);

    t_byte             r_byte;
    logic              active;
    logic [IDX_W-1:0]  pos;
    t_byte             pat_byte;
    logic              wild;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

    // This cell sees the byte INDEX steps back from the newest one, which
    // lines up with pattern position length-1-INDEX.
    always_comb begin
        active   = CELL_POS < i_len;
        pos      = IDX_W'(i_len - CELL_POS - LEN_W'(1));
        pat_byte = i_pattern[pos*BYTE_W +: BYTE_W];
        wild     = i_wild[pos];
        o_ok     = !active || wild || (i_byte == pat_byte);
    end

endmodule
